// File: design/eets_pkg.sv
// ----------------------------------------------------------------------------
// eets_pkg
// types and constants shared by the eeprom transfer sequencer modules
// ----------------------------------------------------------------------------
`default_nettype none

package eets_pkg;

   localparam int unsigned ADDR_W      = 16;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;
   localparam int unsigned QCNT_W      = 3;

   typedef enum logic [2:0] {
      PRIM_START     = 3'd0,
      PRIM_RESTART   = 3'd1,
      PRIM_STOP      = 3'd2,
      PRIM_WRITE     = 3'd3,
      PRIM_READ_ACK  = 3'd4,
      PRIM_READ_NACK = 3'd5,
      PRIM_POLL      = 3'd6
   } prim_type;

   typedef enum logic [13:0] {
      ST_OPEN    = 14'b00000000000001,
      ST_CTRLW   = 14'b00000000000010,
      ST_ADDRH   = 14'b00000000000100,
      ST_ADDRL   = 14'b00000000001000,
      ST_RESTART = 14'b00000000010000,
      ST_CTRLR   = 14'b00000000100000,
      ST_DATA    = 14'b00000001000000,
      ST_PSTOP   = 14'b00000010000000,
      ST_POLL    = 14'b00000100000000,
      ST_PSTART  = 14'b00001000000000,
      ST_PCTRL   = 14'b00010000000000,
      ST_PADDRH  = 14'b00100000000000,
      ST_PADDRL  = 14'b01000000000000,
      ST_STOP    = 14'b10000000000000
   } step_type;

   typedef struct packed {
      logic              open;
      logic              restart;
      logic              rd;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
      logic              last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic valid;
   } qstat_type;

endpackage

`default_nettype wire

// File: design/eets_front.sv
// ----------------------------------------------------------------------------
// eets_front
// accepts byte requests, tracks the running address and open transaction,
// and turns each request into a command for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module eets_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_opcode,
   input  wire logic [eets_pkg::ADDR_W-1:0]   req_start_address,
   input  wire logic [7:0]                    req_write_data,
   input  wire logic                          req_first_byte,
   input  wire logic                          req_last_byte,
   input  wire eets_pkg::qstat_type           qstat,
   output logic                               push,
   output eets_pkg::cmd_type                  cmd
);

   logic [eets_pkg::ADDR_W-1:0] cur_addr_ff, cur_addr_in;
   logic                        open_ff, open_in;
   logic                        opening;

   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;
   assign opening   = req_first_byte || !open_ff;

   always_comb begin
      cmd.open    = opening;
      cmd.restart = open_ff;
      cmd.rd      = req_opcode;
      cmd.addr    = req_first_byte ? req_start_address : cur_addr_ff;
      cmd.wdata   = req_write_data;
      cmd.last    = req_last_byte;
      cur_addr_in = cur_addr_ff;
      open_in     = open_ff;
      if (push) begin
         cur_addr_in = cmd.addr + eets_pkg::ADDR_W'(1);
         open_in     = !req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_addr_ff <= '0;
         open_ff     <= 1'b0;
      end else begin
         cur_addr_ff <= cur_addr_in;
         open_ff     <= open_in;
      end
   end

endmodule

`default_nettype wire

// File: design/eets_queue.sv
// ----------------------------------------------------------------------------
// eets_queue
// short command queue between the front end and the bus sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module eets_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire eets_pkg::cmd_type  push_cmd,
   input  wire logic               pop,
   output eets_pkg::cmd_type       head_cmd,
   output eets_pkg::qstat_type     qstat
);

   eets_pkg::cmd_type                 mem_ff [eets_pkg::QUEUE_DEPTH];
   logic [eets_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [eets_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [eets_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign head_cmd    = mem_ff[rd_ptr_ff];
   assign qstat.valid = (count_ff != '0);
   assign qstat.full  = (count_ff == eets_pkg::QCNT_W'(eets_pkg::QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + eets_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + eets_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + eets_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - eets_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: design/eets_back.sv
// ----------------------------------------------------------------------------
// eets_back
// bus sequencer: steps through the primitives of one command at a time
// and holds them in the result register
// ----------------------------------------------------------------------------
`default_nettype none

module eets_back #(
   parameter int unsigned PAGE_BYTES = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [6:0]                 device_address,
   input  wire eets_pkg::qstat_type        qstat,
   input  wire eets_pkg::cmd_type          head_cmd,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [2:0]                      rsp_primitive_res,
   output logic [7:0]                      rsp_bus_byte,
   output logic                            rsp_run_end
);

   localparam logic [63:0] RECIP_WIDE = ((64'd1 << 32) + 64'(PAGE_BYTES) - 64'd1)
                                        / 64'(PAGE_BYTES);
   localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];

   eets_pkg::step_type               step_ff, step_in, step_nxt;
   eets_pkg::cmd_type                cmd_ff, cmd_in;
   logic                             busy_ff, busy_in;
   logic [eets_pkg::ADDR_W-1:0]      quot_ff, quot_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   eets_pkg::prim_type               prim_ff, prim_in, prim_now;
   logic [7:0]                       byte_ff, byte_in, byte_now;
   logic                             end_ff, end_in, done_now;
   logic                             advance, emit, load;
   logic [eets_pkg::ADDR_W-1:0]      nxt_addr, head_nxt;
   logic [47:0]                      quot_prod;
   logic [31:0]                      page_base;
   logic                             boundary;
   logic [7:0]                       ctrl_w, ctrl_r;

   assign ctrl_w    = {device_address, 1'b0};
   assign ctrl_r    = {device_address, 1'b1};
   assign nxt_addr  = cmd_ff.addr + eets_pkg::ADDR_W'(1);
   assign head_nxt  = head_cmd.addr + eets_pkg::ADDR_W'(1);
   assign quot_prod = {32'd0, head_nxt} * {16'd0, RECIP};
   assign quot_in   = quot_prod[47:32];
   assign page_base = 32'(quot_ff) * 32'(PAGE_BYTES);
   assign boundary  = (page_base == {16'd0, nxt_addr});

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign emit    = busy_ff && advance;

   always_comb begin
      step_nxt = eets_pkg::ST_STOP;
      done_now = 1'b0;
      prim_now = eets_pkg::PRIM_WRITE;
      byte_now = 8'd0;
      unique case (step_ff)
         eets_pkg::ST_OPEN: begin
            prim_now = cmd_ff.restart ? eets_pkg::PRIM_RESTART : eets_pkg::PRIM_START;
            step_nxt = eets_pkg::ST_CTRLW;
         end
         eets_pkg::ST_CTRLW: begin
            byte_now = ctrl_w;
            step_nxt = eets_pkg::ST_ADDRH;
         end
         eets_pkg::ST_ADDRH: begin
            byte_now = cmd_ff.addr[15:8];
            step_nxt = eets_pkg::ST_ADDRL;
         end
         eets_pkg::ST_ADDRL: begin
            byte_now = cmd_ff.addr[7:0];
            step_nxt = cmd_ff.rd ? eets_pkg::ST_RESTART : eets_pkg::ST_DATA;
         end
         eets_pkg::ST_RESTART: begin
            prim_now = eets_pkg::PRIM_RESTART;
            step_nxt = eets_pkg::ST_CTRLR;
         end
         eets_pkg::ST_CTRLR: begin
            byte_now = ctrl_r;
            step_nxt = eets_pkg::ST_DATA;
         end
         eets_pkg::ST_DATA: begin
            if (cmd_ff.rd) begin
               prim_now = cmd_ff.last ? eets_pkg::PRIM_READ_NACK : eets_pkg::PRIM_READ_ACK;
            end else begin
               byte_now = cmd_ff.wdata;
            end
            if (!cmd_ff.rd && boundary) begin
               step_nxt = eets_pkg::ST_PSTOP;
            end else begin
               step_nxt = eets_pkg::ST_STOP;
               done_now = !cmd_ff.last;
            end
         end
         eets_pkg::ST_PSTOP: begin
            prim_now = eets_pkg::PRIM_STOP;
            step_nxt = eets_pkg::ST_POLL;
         end
         eets_pkg::ST_POLL: begin
            prim_now = eets_pkg::PRIM_POLL;
            byte_now = ctrl_w;
            step_nxt = eets_pkg::ST_PSTART;
         end
         eets_pkg::ST_PSTART: begin
            prim_now = eets_pkg::PRIM_START;
            step_nxt = eets_pkg::ST_PCTRL;
         end
         eets_pkg::ST_PCTRL: begin
            byte_now = ctrl_w;
            step_nxt = eets_pkg::ST_PADDRH;
         end
         eets_pkg::ST_PADDRH: begin
            byte_now = nxt_addr[15:8];
            step_nxt = eets_pkg::ST_PADDRL;
         end
         eets_pkg::ST_PADDRL: begin
            byte_now = nxt_addr[7:0];
            step_nxt = eets_pkg::ST_STOP;
            done_now = !cmd_ff.last;
         end
         eets_pkg::ST_STOP: begin
            prim_now = eets_pkg::PRIM_STOP;
            done_now = 1'b1;
         end
         default: begin
            done_now = 1'b1;
         end
      endcase
   end

   assign load = qstat.valid && (!busy_ff || (emit && done_now));
   assign pop  = load;

   always_comb begin
      step_in      = step_ff;
      cmd_in       = cmd_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      prim_in      = prim_ff;
      byte_in      = byte_ff;
      end_in       = end_ff;
      if (advance) begin
         rsp_valid_in = busy_ff;
      end
      if (emit) begin
         prim_in = prim_now;
         byte_in = byte_now;
         end_in  = done_now;
         step_in = step_nxt;
         if (done_now) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         cmd_in  = head_cmd;
         busy_in = 1'b1;
         step_in = head_cmd.open ? eets_pkg::ST_OPEN : eets_pkg::ST_DATA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= eets_pkg::ST_OPEN;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      prim_ff <= prim_in;
      byte_ff <= byte_in;
      end_ff  <= end_in;
      if (load) begin
         quot_ff <= quot_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_primitive_res = prim_ff;
   assign rsp_bus_byte      = byte_ff;
   assign rsp_run_end       = end_ff;

`ifndef SYNTHESIS
   a_idle_loads: assert property (@(posedge clock) disable iff (reset)
      !busy_ff && qstat.valid |=> busy_ff)
      else $error("sequencer left a queued command waiting");

   a_restart_only_reads: assert property (@(posedge clock) disable iff (reset)
      busy_ff && step_ff == eets_pkg::ST_RESTART |-> cmd_ff.rd)
      else $error("read restart on a write command");

   a_page_only_writes: assert property (@(posedge clock) disable iff (reset)
      busy_ff && step_ff == eets_pkg::ST_PSTOP |-> !cmd_ff.rd)
      else $error("page reopen on a read command");
`endif

endmodule

`default_nettype wire

// File: design/i2c_eeprom_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_transfer_sequencer
// turns eeprom byte requests into runs of i2c master primitives
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    opcode, start_address, write_data,
//                                          first_byte, last_byte
//   rsp      out        rsp_valid/stall    primitive_res, bus_byte, run_end
//   csr      in         apb psel/penable   device_address at byte address 0
//
// one primitive leaves per clock unless the result side stalls, and an item
// causes 1 to 12 primitives; a four-entry queue lets the front take items
// while the sequencer works.
// synchronous active-high reset empties the queue and clears the address.
// a stalled result holds the sequencer; a full queue stalls requests.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_eeprom_transfer_sequencer #(
   parameter int unsigned PAGE_BYTES = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_opcode,
   input  wire logic [eets_pkg::ADDR_W-1:0]  req_start_address,
   input  wire logic [7:0]                   req_write_data,
   input  wire logic                         req_first_byte,
   input  wire logic                         req_last_byte,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [2:0]                        rsp_primitive_res,
   output logic [7:0]                        rsp_bus_byte,
   output logic                              rsp_run_end,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [1:0]                   csr_paddr,
   input  wire logic [31:0]                  csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;

   logic [6:0]          dev_addr_ff, dev_addr_in;
   logic                push, pop;
   eets_pkg::cmd_type   push_cmd, head_cmd;
   eets_pkg::qstat_type qstat;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_DEVICE_ADDRESS) ? {25'd0, dev_addr_ff} : 32'd0;

   always_comb begin
      dev_addr_in = dev_addr_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr == REG_DEVICE_ADDRESS) begin
         dev_addr_in = csr_pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= 7'd80;
      end else begin
         dev_addr_ff <= dev_addr_in;
      end
   end

   eets_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_start_address (req_start_address),
      .req_write_data    (req_write_data),
      .req_first_byte    (req_first_byte),
      .req_last_byte     (req_last_byte),
      .qstat             (qstat),
      .push              (push),
      .cmd               (push_cmd)
   );

   eets_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .qstat    (qstat)
   );

   eets_back #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .device_address    (dev_addr_ff),
      .qstat             (qstat),
      .head_cmd          (head_cmd),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_primitive_res (rsp_primitive_res),
      .rsp_bus_byte      (rsp_bus_byte),
      .rsp_run_end       (rsp_run_end)
   );

endmodule

`default_nettype wire

// File: sim/eets_checker.sv
// ----------------------------------------------------------------------------
// eets_checker
// Watches the request, result and register channels of the eeprom transfer
// sequencer. It keeps its own copy of the running address, the open flag
// and the device address, and predicts the bus primitives for every
// accepted item. Each accepted primitive is compared with the oldest one
// still expected. The checker hands its counts to the testbench top.
// ----------------------------------------------------------------------------

package eets_tb_pkg;

   localparam logic       OP_WRITE             = 1'b0;
   localparam logic       OP_READ              = 1'b1;
   localparam logic [1:0] CSR_DEVICE_ADDRESS   = 2'd0;
   localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd80;

endpackage

module eets_checker #(
   parameter int unsigned PAGE_BYTES = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_stall,
   input  wire logic                        req_opcode,
   input  wire logic [eets_pkg::ADDR_W-1:0] req_start_address,
   input  wire logic [7:0]                  req_write_data,
   input  wire logic                        req_first_byte,
   input  wire logic                        req_last_byte,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   input  wire logic [2:0]                  rsp_primitive_res,
   input  wire logic [7:0]                  rsp_bus_byte,
   input  wire logic                        rsp_run_end,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [1:0]                  csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   input  wire logic                        csr_pready,
   output int unsigned                      mismatch_count,
   output int unsigned                      pending_prims,
   output int unsigned                      items_seen,
   output int unsigned                      prims_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      eets_pkg::prim_type kind;
      logic [7:0]         bus_byte;
      logic               run_end;
   } bus_prim_type;

   bus_prim_type expected_prims[$];
   logic [6:0]   dev_addr   = eets_tb_pkg::DEVICE_ADDRESS_RESET;
   logic [15:0]  mem_addr   = '0;
   logic         xfer_open  = 1'b0;
   int unsigned  mismatches = 0;
   int unsigned  items      = 0;
   int unsigned  prims      = 0;

   function automatic logic [7:0] control_byte(logic rd);
      return {dev_addr, rd};
   endfunction

   function automatic void add_prim(eets_pkg::prim_type kind, logic [7:0] value);
      bus_prim_type p;
      p.kind     = kind;
      p.bus_byte = value;
      p.run_end  = 1'b0;
      expected_prims.push_back(p);
   endfunction

   function automatic void add_addressing(eets_pkg::prim_type open_kind);
      add_prim(open_kind, 8'h00);
      add_prim(eets_pkg::PRIM_WRITE, control_byte(1'b0));
      add_prim(eets_pkg::PRIM_WRITE, mem_addr[15:8]);
      add_prim(eets_pkg::PRIM_WRITE, mem_addr[7:0]);
   endfunction

   function automatic void predict_primitives(logic op, logic [15:0] start,
                                              logic [7:0] wdata, logic first,
                                              logic last);
      eets_pkg::prim_type open_kind;
      if (first || !xfer_open) begin
         open_kind = xfer_open ? eets_pkg::PRIM_RESTART : eets_pkg::PRIM_START;
         if (first)
            mem_addr = start;
         add_addressing(open_kind);
         if (op == eets_tb_pkg::OP_READ) begin
            add_prim(eets_pkg::PRIM_RESTART, 8'h00);
            add_prim(eets_pkg::PRIM_WRITE, control_byte(1'b1));
         end
         xfer_open = 1'b1;
      end
      if (op == eets_tb_pkg::OP_WRITE) begin
         add_prim(eets_pkg::PRIM_WRITE, wdata);
         mem_addr = mem_addr + 16'd1;
         // page boundary: stop, poll for completion, readdress
         if ((mem_addr % PAGE_BYTES) == 0) begin
            add_prim(eets_pkg::PRIM_STOP, 8'h00);
            add_prim(eets_pkg::PRIM_POLL, control_byte(1'b0));
            add_addressing(eets_pkg::PRIM_START);
         end
      end else begin
         add_prim(last ? eets_pkg::PRIM_READ_NACK : eets_pkg::PRIM_READ_ACK, 8'h00);
         mem_addr = mem_addr + 16'd1;
      end
      if (last) begin
         add_prim(eets_pkg::PRIM_STOP, 8'h00);
         xfer_open = 1'b0;
      end
      expected_prims[expected_prims.size()-1].run_end = 1'b1;
   endfunction

   always @(posedge clock) begin
      bus_prim_type want;
      if (reset) begin
         expected_prims.delete();
         dev_addr  = eets_tb_pkg::DEVICE_ADDRESS_RESET;
         mem_addr  = '0;
         xfer_open = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            prims++;
            if (expected_prims.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected primitive %0d byte %02h end %0b", $realtime,
                           rsp_primitive_res, rsp_bus_byte, rsp_run_end);
            end else begin
               want = expected_prims.pop_front();
               if (rsp_primitive_res !== want.kind || rsp_bus_byte !== want.bus_byte ||
                   rsp_run_end !== want.run_end) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: primitive %0d: expected %s byte %02h end %0b,",
                               " got %0d byte %02h end %0b"},
                              $realtime, prims, want.kind.name(), want.bus_byte,
                              want.run_end, rsp_primitive_res, rsp_bus_byte,
                              rsp_run_end);
               end
            end
         end
         if (req_valid && !req_stall) begin
            items++;
            predict_primitives(req_opcode, req_start_address, req_write_data,
                               req_first_byte, req_last_byte);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == eets_tb_pkg::CSR_DEVICE_ADDRESS)
            dev_addr = csr_pwdata[6:0];
      end
      mismatch_count <= mismatches;
      pending_prims  <= expected_prims.size();
      items_seen     <= items;
      prims_seen     <= prims;
   end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench top for the eeprom transfer sequencer. Drives eeprom byte
// requests and device address writes, idles both channels at random, holds
// the result side off for a long stretch once, and gives the verdict from
// the counts of the checker that sits beside the block.
// ----------------------------------------------------------------------------

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PAGE_BYTES       = 64;
   localparam int unsigned DIRECTED_ITEMS   = 22;
   localparam int unsigned PHASE_ITEMS      = 77;
   localparam int unsigned ITEM_TARGET      = DIRECTED_ITEMS + 4 * PHASE_ITEMS;
   localparam int unsigned QUIET_ITEMS      = 40;
   localparam int unsigned HOLD_ITEMS       = 24;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned WATCHDOG_LIMIT   = 3000;

   logic        clock;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   wire         req_stall;
   logic        req_opcode        = eets_tb_pkg::OP_WRITE;
   logic [15:0] req_start_address = '0;
   logic [7:0]  req_write_data    = '0;
   logic        req_first_byte    = 1'b0;
   logic        req_last_byte     = 1'b0;
   wire         rsp_valid;
   logic        rsp_stall         = 1'b0;
   wire  [2:0]  rsp_primitive_res;
   wire  [7:0]  rsp_bus_byte;
   wire         rsp_run_end;
   logic        csr_psel          = 1'b0;
   logic        csr_penable       = 1'b0;
   logic        csr_pwrite        = 1'b0;
   logic [1:0]  csr_paddr         = '0;
   logic [31:0] csr_pwdata        = '0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   int unsigned mismatch_count;
   int unsigned pending_prims;
   int unsigned items_seen;
   int unsigned prims_seen;

   int unsigned items_sent   = 0;
   int unsigned gap_pct      = 0;
   int unsigned stall_pct    = 0;
   int unsigned quiet_cycles = 0;
   logic        quiet        = 1'b0;
   logic        hold_request = 1'b0;

   i2c_eeprom_transfer_sequencer #(.PAGE_BYTES(PAGE_BYTES)) uut (.*);

   eets_checker #(.PAGE_BYTES(PAGE_BYTES)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic send_item(logic op, logic [15:0] start, logic [7:0] data,
                            logic first, logic last);
      int unsigned n;
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         n = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_start_address <= start;
      req_write_data    <= data;
      req_first_byte    <= first;
      req_last_byte     <= last;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_prims != 0);
   endtask

   task automatic write_device_address(logic [6:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= eets_tb_pkg::CSR_DEVICE_ADDRESS;
      csr_pwdata  <= {25'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic random_transfer(int unsigned budget);
      int unsigned len;
      int unsigned pick;
      int unsigned mode;
      logic [15:0] base;
      logic        broken;
      logic        op;
      logic        first;
      logic        last;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         len = $urandom_range(1, 6);
      else if (pick < 92)
         len = $urandom_range(7, 20);
      else
         len = $urandom_range(40, 70);
      if (len > budget)
         len = budget;
      case ($urandom_range(0, 3))
         0: base = 16'($urandom);
         1: base = (16'($urandom) | 16'(PAGE_BYTES - 1)) - 16'($urandom_range(0, 3));
         2: base = 16'hFFFF - 16'($urandom_range(0, 5));
         default: base = 16'($urandom_range(0, 255));
      endcase
      mode   = $urandom_range(0, 9);
      broken = ($urandom_range(0, 99) < 15);
      for (int unsigned i = 0; i < len; i++) begin
         if (mode < 4)
            op = eets_tb_pkg::OP_WRITE;
         else if (mode < 7)
            op = eets_tb_pkg::OP_READ;
         else
            op = 1'($urandom);
         first = (i == 0);
         last  = (i == len - 1);
         if (broken) begin
            first = ($urandom_range(0, 3) == 0);
            last  = ($urandom_range(0, 3) == 0);
         end
         send_item(op, first ? base : 16'($urandom), 8'($urandom), first, last);
      end
   endtask

   // result side: random stall bursts, plus one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      int unsigned phase;
      int unsigned phase_end;
      int unsigned hold_end;
      logic [6:0]  phase_addr;

      repeat (5) @(posedge clock);
      reset     <= 1'b0;
      gap_pct   = 20;
      stall_pct = 20;

      // reset device address; page wrap mid-transfer, reads, unopened and reopened transfers
      send_item(eets_tb_pkg::OP_WRITE, 16'h003E, 8'h00, 1'b1, 1'b0);
      send_item(eets_tb_pkg::OP_WRITE, 16'h0000, 8'hFF, 1'b0, 1'b0);
      send_item(eets_tb_pkg::OP_WRITE, 16'hFFFF, 8'hA5, 1'b0, 1'b1);
      send_item(eets_tb_pkg::OP_READ,  16'hFFFF, 8'h00, 1'b1, 1'b0);
      send_item(eets_tb_pkg::OP_READ,  16'h0000, 8'hFF, 1'b0, 1'b1);
      send_item(eets_tb_pkg::OP_WRITE, 16'h1111, 8'h5A, 1'b0, 1'b0);
      send_item(eets_tb_pkg::OP_WRITE, 16'hFFFF, 8'h81, 1'b1, 1'b1);
      send_item(eets_tb_pkg::OP_READ,  16'h2222, 8'h00, 1'b0, 1'b1);
      send_item(eets_tb_pkg::OP_WRITE, 16'h1234, 8'h7E, 1'b1, 1'b0);
      send_item(eets_tb_pkg::OP_READ,  16'h0000, 8'h00, 1'b0, 1'b0);
      send_item(eets_tb_pkg::OP_WRITE, 16'h0000, 8'hE7, 1'b0, 1'b1);
      send_item(eets_tb_pkg::OP_READ,  16'h8000, 8'h00, 1'b1, 1'b1);
      send_item(eets_tb_pkg::OP_READ,  16'h7FFF, 8'h00, 1'b1, 1'b0);
      send_item(eets_tb_pkg::OP_READ,  16'h00C0, 8'h00, 1'b1, 1'b0);
      send_item(eets_tb_pkg::OP_READ,  16'h0000, 8'h00, 1'b0, 1'b1);
      drain();
      write_device_address(7'h7F);
      send_item(eets_tb_pkg::OP_WRITE, 16'h0000, 8'hFF, 1'b1, 1'b1);
      send_item(eets_tb_pkg::OP_READ,  16'hFFFF, 8'h00, 1'b1, 1'b1);
      send_item(eets_tb_pkg::OP_WRITE, 16'hFFBF, 8'h00, 1'b1, 1'b1);
      drain();
      write_device_address(7'h00);
      send_item(eets_tb_pkg::OP_WRITE, 16'hFFFF, 8'h3C, 1'b0, 1'b0);
      send_item(eets_tb_pkg::OP_WRITE, 16'h0000, 8'hC3, 1'b0, 1'b1);
      send_item(eets_tb_pkg::OP_READ,  16'h5555, 8'h00, 1'b1, 1'b1);
      send_item(eets_tb_pkg::OP_WRITE, 16'hAAAA, 8'h99, 1'b1, 1'b1);

      for (phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0: phase_addr = 7'($urandom_range(1, 126));
            1: phase_addr = 7'h7F;
            2: phase_addr = 7'h00;
            default: phase_addr = 7'($urandom);
         endcase
         write_device_address(phase_addr);
         case (phase)
            0: stall_pct = 25;
            1: stall_pct = 10;
            2: stall_pct = 40;
            default: stall_pct = 15;
         endcase
         phase_end = DIRECTED_ITEMS + (phase + 1) * PHASE_ITEMS;
         if (phase == 1) begin
            // long result hold while requests keep coming
            hold_request = 1'b1;
            gap_pct      = 0;
            hold_end     = items_sent + HOLD_ITEMS;
            while (items_sent < hold_end)
               random_transfer(hold_end - items_sent);
         end
         while (items_sent < phase_end) begin
            if (items_sent + QUIET_ITEMS >= ITEM_TARGET) begin
               quiet     = 1'b1;
               gap_pct   = 0;
               stall_pct = 0;
            end else begin
               case ($urandom_range(0, 3))
                  0, 1: gap_pct = 0;
                  2: gap_pct = 10;
                  default: gap_pct = 40;
               endcase
            end
            if ($urandom_range(0, 19) == 0)
               send_item(1'($urandom), 16'($urandom), 8'($urandom), 1'($urandom),
                         1'($urandom));
            else
               random_transfer(phase_end - items_sent);
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("run covered %0d items and %0d bus primitives under five device addresses,",
               items_seen, prims_seen);
      $display("with page wraps, unopened and reopened transfers, and a %0d-cycle output hold",
               LONG_HOLD_CYCLES);
      if (mismatch_count == 0 && pending_prims == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d primitives never seen", mismatch_count, pending_prims);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
